// ===== rtl/ghms_pkg.sv =====
`timescale 1ns / 1ps

package ghms_pkg;

  localparam int CS_W    = 16;  // cell_size width
  localparam int H_W     = 16;  // stored height width
  localparam int POS_W   = 24;  // center/top width
  localparam int EXT_W   = 23;  // extent width
  localparam int RC_W    = 8;   // read column/row width
  localparam int DIVD_W  = 26;  // dividend width (|2*center - extent|)
  localparam int DIVS_W  = 17;  // divisor width (2*cell_size)
  localparam int DCNT_W  = 5;   // divider step counter
  localparam int TW      = 30;  // signed width for index arithmetic

  localparam logic [H_W-1:0] EMPTY_H = 16'h8000;
  localparam logic [H_W-1:0] H_MAX   = 16'h7FFF;

  localparam logic CFG_CELL_SIZE     = 1'b0;
  localparam logic CFG_HEIGHT_OFFSET = 1'b1;

  localparam logic KIND_STAMP = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_RANGE,
    S_WALK,
    S_DRAIN,
    S_RD,
    S_RDW,
    S_FIN
  } state_t;

endpackage

// ===== rtl/grid_height_map_stamper.sv =====
`timescale 1ns / 1ps

// Read item: memory read (S_RD), capture (S_RDW) and output (S_FIN); one item at a time.
// Stamp item: four divisions on the shared one-bit-per-cycle divider (load + 26 steps each),
//   a range step, then a walk of one covered cell per cycle (read-modify-write on the single
//   grid memory) and a drain step; a box entirely off the grid skips the walk and finishes
//   straight after the range step. Disabled stamps or a zero cell size go straight to the finish.
// Reset (synchronous, active low) clears control state and runs a clearing pass over all
//   GRID_SIDE*GRID_SIDE cells writing the empty marker; no item is accepted meanwhile.
module grid_height_map_stamper #(
  parameter int GRID_SIDE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [23:0] center_x, [47:24] center_y, [71:48] top_z, [94:72] extent_x,
  // [117:95] extent_y, [125:118] cell_col, [133:126] cell_row, [135:134] zero
  input  logic [135:0]                in_tdata,
  // [0] kind, [1] is_fixed
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] cell_height
  output logic [15:0]                 out_tdata,
  // [0] answer_kind
  output logic                        out_tuser,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ghms_pkg::CS_W-1:0]   cfg_wdata
);
  import ghms_pkg::*;

  localparam int IDX_W  = $clog2(GRID_SIDE);
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic signed [TW-1:0] HALF_S = TW'(GRID_SIDE / 2);
  localparam logic signed [TW-1:0] GMAX_S = TW'(GRID_SIDE - 1);

  state_t state_r, state_nxt;

  logic [CS_W-1:0]         cell_size_r;
  logic signed [H_W-1:0]   h_off_r;

  logic                    kind_r;
  logic signed [POS_W-1:0] cx_r, cy_r, tz_r;
  logic [EXT_W-1:0]        ex_r, ey_r;
  logic [RC_W-1:0]         rcol_r, rrow_r;

  logic [1:0]              div_sel_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic [DIVD_W-1:0]       dq_r;
  logic [DIVS_W-1:0]       drem_r;
  logic [DIVD_W-1:0]       qres_r [4];
  logic [3:0]              rnz_r;

  logic signed [H_W-1:0]   z_h_r;
  logic [IDX_W-1:0]        col_lo_r, col_hi_r, row_lo_r, row_hi_r, col_r, row_r;
  logic                    pend_v_r;
  logic [ADDR_W-1:0]       pend_addr_r;
  logic [ADDR_W-1:0]       clr_cnt_r;
  logic [H_W-1:0]          rd_data_r;
  logic [H_W-1:0]          res_h_r;
  logic                    out_valid_r, out_kind_r;
  logic [H_W-1:0]          out_h_r;

  logic [H_W-1:0]          mem [DEPTH];

  // ---------------- datapath helpers ----------------
  logic signed [DIVD_W-1:0] sx, sy;
  logic [DIVD_W-1:0]        div_op;
  logic [DIVS_W-1:0]        div_s;
  logic [DIVS_W:0]          rem_sh;
  logic                     q_bit;
  logic [DIVS_W-1:0]        rem_new;
  logic                     div_last;

  assign sx = {cx_r[POS_W-1], cx_r, 1'b0} - DIVD_W'(ex_r);
  assign sy = {cy_r[POS_W-1], cy_r, 1'b0} - DIVD_W'(ey_r);
  assign div_s = {cell_size_r, 1'b0};

  always_comb begin
    case (div_sel_r)
      2'd0:    div_op = sx[DIVD_W-1] ? DIVD_W'(-sx) : DIVD_W'(sx);
      2'd1:    div_op = {2'b00, ex_r, 1'b0};
      2'd2:    div_op = sy[DIVD_W-1] ? DIVD_W'(-sy) : DIVD_W'(sy);
      default: div_op = {2'b00, ey_r, 1'b0};
    endcase
  end

  assign rem_sh  = {drem_r, dq_r[DIVD_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, div_s});
  assign rem_new = q_bit ? DIVS_W'(rem_sh - {1'b0, div_s}) : DIVS_W'(rem_sh);
  assign div_last = (dcnt_r == DCNT_W'(DIVD_W - 1));

  // index range per axis: the covered cells form one contiguous run
  logic signed [TW-1:0] trs [2], q0 [2], tl [2], trl [2], lo_f [2], hi_f [2];
  logic [IDX_W-1:0]     lo_c [2], hi_c [2];
  logic [1:0]           ax_empty;
  logic [1:0]           ax_neg;

  assign ax_neg = {sy[DIVD_W-1], sx[DIVD_W-1]};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      trs[a] = ax_neg[a] ? -TW'(qres_r[2*a]) : TW'(qres_r[2*a]);
      q0[a]  = trs[a] - ((ax_neg[a] && rnz_r[2*a]) ? TW'(1) : TW'(0));
      tl[a]  = q0[a] + TW'(qres_r[2*a+1]) + TW'(rnz_r[2*a+1]);
      trl[a] = tl[a] + ((tl[a] < 0 && rnz_r[2*a]) ? TW'(1) : TW'(0));
      lo_f[a] = trs[a] + HALF_S;
      hi_f[a] = trl[a] + HALF_S;
      ax_empty[a] = (lo_f[a] > GMAX_S) || (hi_f[a] < 0);
      lo_c[a] = (lo_f[a] < 0) ? '0 : IDX_W'(lo_f[a]);
      hi_c[a] = (hi_f[a] > GMAX_S) ? IDX_W'(GRID_SIDE - 1) : IDX_W'(hi_f[a]);
    end
  end

  // floored top plus offset, saturated
  logic signed [H_W:0]   z_sum;
  logic signed [H_W-1:0] z_sat;
  assign z_sum = (H_W+1)'($signed(tz_r[POS_W-1:8])) + (H_W+1)'(h_off_r);
  always_comb begin
    if (z_sum > $signed((H_W+1)'(H_MAX)))
      z_sat = H_MAX;
    else if (z_sum < -$signed((H_W+1)'(EMPTY_H)))
      z_sat = EMPTY_H;
    else
      z_sat = H_W'(z_sum);
  end

  logic walk_row_end, walk_last;
  assign walk_row_end = (row_r == row_hi_r);
  assign walk_last    = walk_row_end && (col_r == col_hi_r);

  logic rd_in_grid;
  assign rd_in_grid = (32'(rcol_r) < GRID_SIDE) && (32'(rrow_r) < GRID_SIDE);

  logic [ADDR_W-1:0] walk_addr, rd_addr;
  assign walk_addr = ADDR_W'(32'(col_r) * GRID_SIDE + 32'(row_r));
  assign rd_addr   = ADDR_W'(32'(rcol_r) * GRID_SIDE + 32'(rrow_r));

  logic fin_go;
  assign fin_go = !out_valid_r || out_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == KIND_READ)
            state_nxt = S_RD;
          else if (!in_tuser[1] || cell_size_r == '0)
            state_nxt = S_FIN;
          else
            state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_last) state_nxt = (div_sel_r == 2'd3) ? S_RANGE : S_LOAD;
      end
      S_RANGE: state_nxt = (ax_empty != 2'b00) ? S_FIN : S_WALK;
      S_WALK:  if (walk_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_RD:    state_nxt = S_RDW;
      S_RDW:   state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- outputs / memory control ----------------
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [H_W-1:0]    mem_wdata;

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = z_h_r;
    mem_raddr = rd_addr;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = EMPTY_H;
      end
      S_IDLE: in_tready = 1'b1;
      S_WALK: begin
        mem_raddr = walk_addr;
        mem_we    = pend_v_r && ($signed(rd_data_r) < z_h_r);
      end
      S_DRAIN: mem_we = pend_v_r && ($signed(rd_data_r) < z_h_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cell_size_r <= CS_W'(256);
      h_off_r     <= '0;
      div_sel_r   <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        if (cfg_index == CFG_CELL_SIZE) cell_size_r <= cfg_wdata;
        else                            h_off_r     <= cfg_wdata;
      end

      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);

      pend_v_r <= (state_r == S_WALK);

      if (state_r == S_IDLE) div_sel_r <= '0;
      if (state_r == S_LOAD) dcnt_r <= '0;
      else if (state_r == S_DIV) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
        if (div_last) div_sel_r <= div_sel_r + 2'd1;
      end

      if (state_r == S_FIN && fin_go) out_valid_r <= 1'b1;
      else if (out_tready)            out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      kind_r  <= in_tuser[0];
      cx_r    <= in_tdata[23:0];
      cy_r    <= in_tdata[47:24];
      tz_r    <= in_tdata[71:48];
      ex_r    <= in_tdata[94:72];
      ey_r    <= in_tdata[117:95];
      rcol_r  <= in_tdata[125:118];
      rrow_r  <= in_tdata[133:126];
      res_h_r <= '0;
    end

    if (state_r == S_LOAD) begin
      dq_r   <= div_op;
      drem_r <= '0;
    end else if (state_r == S_DIV) begin
      dq_r   <= {dq_r[DIVD_W-2:0], q_bit};
      drem_r <= rem_new;
      if (div_last) begin
        qres_r[div_sel_r] <= {dq_r[DIVD_W-2:0], q_bit};
        rnz_r[div_sel_r]  <= (rem_new != '0);
      end
    end

    if (state_r == S_RANGE) begin
      z_h_r    <= z_sat;
      col_lo_r <= lo_c[0];
      col_hi_r <= hi_c[0];
      row_lo_r <= lo_c[1];
      row_hi_r <= hi_c[1];
      col_r    <= lo_c[0];
      row_r    <= lo_c[1];
    end else if (state_r == S_WALK) begin
      pend_addr_r <= walk_addr;
      if (walk_row_end) begin
        row_r <= row_lo_r;
        col_r <= col_r + IDX_W'(1);
      end else begin
        row_r <= row_r + IDX_W'(1);
      end
    end

    if (state_r == S_RDW) res_h_r <= rd_in_grid ? rd_data_r : EMPTY_H;

    if (state_r == S_FIN && fin_go) begin
      out_kind_r <= kind_r;
      out_h_r    <= res_h_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_h_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTH
  // the pending write-back never collides with the read issued in the same cycle
  a_no_rmw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && pend_v_r) |-> (pend_addr_r != walk_addr))
    else $error("walk read hits pending write address");

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (col_r <= col_hi_r && row_r <= row_hi_r &&
                             col_r >= col_lo_r && row_r >= row_lo_r))
    else $error("walk counter left its range");

  a_pend_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> $past(state_r == S_WALK))
    else $error("write-back without a walk read");
`endif

endmodule

// ===== bench/grid_height_map_stamper_test.sv =====
`timescale 1ns / 1ps

module grid_height_map_stamper_test;
  import ghms_pkg::*;

  localparam int SIDE = 256;
  localparam longint CYCLE_LIMIT = 4000000;

  // Tracks the height grid and the results still owed by the block.
  class height_scoreboard;
    shortint height_map[SIDE*SIDE];
    longint pitch;
    longint z_offset;
    bit [16:0] owed[$];  // {kind, height}
    int errors;
    bit col_mark[SIDE];
    bit row_mark[SIDE];

    function new();
      foreach (height_map[i]) height_map[i] = -32768;
      pitch = 256;
      z_offset = 0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_CELL_SIZE) pitch = longint'(val);
      else z_offset = longint'($signed(val));
    endfunction

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && (a < 0)) q -= 1;
      return q;
    endfunction

    // c, e, s in 1/512 units: c = 2*center, s = 2*pitch
    function void cover_axis(longint c, longint e, longint s, output bit hit[SIDE]);
      longint start, span, n, f, lo, hi, idx;
      start = c - e;
      span = 2 * e + s;
      n = (span + s - 1) / s;
      f = floor_quot(start, s);
      lo = -(SIDE / 2) - f - 2;
      hi = SIDE - SIDE / 2 - f + 1;
      foreach (hit[i]) hit[i] = 0;
      if (lo < 0) lo = 0;
      if (hi > n - 1) hi = n - 1;
      for (longint k = lo; k <= hi; k++) begin
        idx = (start + k * s) / s + SIDE / 2;
        if (idx >= 0 && idx < SIDE) hit[idx] = 1;
      end
    endfunction

    function void note_item(logic kind, logic fixed, logic [135:0] d);
      longint z;
      logic [15:0] h;
      h = 16'd0;
      if (kind == KIND_STAMP) begin
        if (fixed && pitch != 0) begin
          z = floor_quot(longint'($signed(d[71:48])), 256) + z_offset;
          if (z > 32767) z = 32767;
          if (z < -32768) z = -32768;
          cover_axis(2 * longint'($signed(d[23:0])), longint'(d[94:72]), 2 * pitch, col_mark);
          cover_axis(2 * longint'($signed(d[47:24])), longint'(d[117:95]), 2 * pitch, row_mark);
          for (int c = 0; c < SIDE; c++)
            if (col_mark[c])
              for (int r = 0; r < SIDE; r++)
                if (row_mark[r] && longint'(height_map[c*SIDE+r]) < z)
                  height_map[c*SIDE+r] = shortint'(z);
        end
      end else begin
        h = height_map[int'(d[125:118])*SIDE + int'(d[133:126])];
      end
      owed.push_back({kind, h});
    endfunction

    function void check(logic kind, logic [15:0] h);
      bit [16:0] want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: kind %0d height %0d", kind, $signed(h));
        return;
      end
      want = owed.pop_front();
      if (want != {kind, h}) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d height %0d, got kind %0d height %0d",
                   want[16], $signed(want[15:0]), kind, $signed(h));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [CS_W-1:0] cfg_wdata = '0;

  height_scoreboard sb = new();
  bit calm = 0;
  longint cycles = 0;

  grid_height_map_stamper dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tuser, out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 21);
  end

  function automatic logic [135:0] pack(longint cx, longint cy, longint z, longint ex,
                                        longint ey, int col, int row);
    return {2'b00, row[7:0], col[7:0], ey[22:0], ex[22:0], z[23:0], cy[23:0], cx[23:0]};
  endfunction

  task automatic send(logic kind, logic fixed, logic [135:0] d);
    in_tuser <= {fixed, kind};
    in_tdata <= d;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, fixed, d);
    if (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic stamp(logic fixed, longint cx, longint cy, longint z, longint ex, longint ey);
    send(KIND_STAMP, fixed, pack(cx, cy, z, ex, ey, $urandom_range(255), $urandom_range(255)));
  endtask

  task automatic read_cell(int col, int row);
    send(KIND_READ, $urandom_range(1), pack($urandom, $urandom, $urandom, $urandom, $urandom,
                                             col, row));
  endtask

  // Half cell reads (mostly near the grid center), small boxes near the grid center; some noise and disabled boxes.
  task automatic random_item(longint cs);
    longint p, cx, cy, ex, ey;
    int pick;
    p = (cs == 0) ? 256 : cs;
    pick = $urandom_range(99);
    if (pick < 45) begin
      read_cell(128 + $urandom_range(56) - 28, 128 + $urandom_range(56) - 28);
    end else if (pick < 50) begin
      read_cell($urandom_range(255), $urandom_range(255));
    end else if (pick < 85) begin
      cx = ($urandom_range(60) - 30) * p + $urandom_range(p - 1);
      cy = ($urandom_range(60) - 30) * p + $urandom_range(p - 1);
      ex = ($urandom_range(99) < 5 ? $urandom_range(40) : $urandom_range(8)) * p
           + $urandom_range(p - 1);
      ey = $urandom_range(8) * p + $urandom_range(p - 1);
      stamp(1, cx, cy, longint'($signed(24'($urandom))), ex, ey);
    end else if (pick < 92) begin
      stamp(1, $urandom, $urandom, $urandom, $urandom_range(4 * p), $urandom_range(4 * p));
    end else begin
      stamp(0, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    longint pitches[7];
    longint offsets[7];
    pitches = '{1, 65535, 0, 300, 128, 0, 0};
    offsets = '{100, -32768, 5, 32767, -200, 0, 0};
    pitches[5] = $urandom_range(1, 2000);
    pitches[6] = $urandom_range(1, 65535);
    offsets[5] = $urandom_range(65535) - 32768;
    offsets[6] = $urandom_range(200) - 100;

    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed, reset register values
    read_cell(128, 128);
    stamp(1, 0, 0, 5 * 256 + 128, 0, 0);
    read_cell(128, 128);
    read_cell(127, 127);
    stamp(1, 0, 0, -384, 3 * 256, 3 * 256);
    read_cell(128, 128);
    read_cell(127, 129);
    stamp(0, 0, 0, 8388607, 8388607, 8388607);
    read_cell(130, 130);
    stamp(1, 0, 0, -100 * 256, 8388607, 8388607);
    read_cell(0, 0);
    read_cell(255, 255);
    read_cell(0, 255);
    stamp(1, -8388608, 8388607, 8388607, 0, 0);
    stamp(1, -128 * 256, 127 * 256 + 255, 40 * 256, 256, 0);
    read_cell(0, 255);
    read_cell(1, 255);
    stamp(1, 127 * 256 + 255, -128 * 256, -8388608, 512, 512);
    read_cell(255, 0);
    drain();

    write_reg(CFG_HEIGHT_OFFSET, 16'h7FFF);
    stamp(1, 10 * 256, 10 * 256, 8388607, 0, 0);
    read_cell(138, 138);
    drain();
    write_reg(CFG_HEIGHT_OFFSET, 16'h8000);
    stamp(1, 20 * 256, 20 * 256, -8388608, 0, 0);
    read_cell(148, 148);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_CELL_SIZE, 16'(pitches[ph]));
      write_reg(CFG_HEIGHT_OFFSET, 16'(offsets[ph]));
      calm = (ph == 3);
      for (int i = 0; i < 275; i++) random_item(pitches[ph]);
      drain();
    end
    calm = 0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ghms_pkg.sv
rtl/grid_height_map_stamper.sv
bench/grid_height_map_stamper_test.sv
